FILE: design/ottb_pkg.sv
package ottb_pkg;

    typedef enum logic [1:0] {
        KIND_ARM     = 2'd0,
        KIND_ARM_NOW = 2'd1,
        KIND_STOP    = 2'd2,
        KIND_SCAN    = 2'd3
    } t_kind;

    localparam int KIND_W  = 2;
    localparam int MASK_W  = 16;
    localparam int DELAY_W = 16;
    localparam int NOW_W   = 32;
    localparam int SLOT_W  = 4;

    typedef struct packed {
        logic we;
        logic act_set;
        logic act_clr;
    } t_store_ctl;

endpackage

FILE: design/ottb_if.sv
interface ottb_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [ottb_pkg::KIND_W-1:0]   kind;
    logic [ottb_pkg::MASK_W-1:0]   task_mask;
    logic [ottb_pkg::DELAY_W-1:0]  delay_ms;
    logic [ottb_pkg::NOW_W-1:0]    now;
    logic                          run_enabled;

    modport source (output valid, kind, task_mask, delay_ms, now, run_enabled, input ready);
    modport sink   (input valid, kind, task_mask, delay_ms, now, run_enabled, output ready);
endinterface

interface ottb_res_if;
    logic                          valid;
    logic                          ready;
    logic                          fired;
    logic [ottb_pkg::SLOT_W-1:0]   slot;
    logic                          last;

    modport source (output valid, fired, slot, last, input ready);
    modport sink   (input valid, fired, slot, last, output ready);
endinterface

FILE: design/one_shot_task_timer_bank_unit.sv
// Bank of SLOTS one-shot timers on a TIMELINE_BITS-wide timeline. A command
// word (arm, arm immediate, stop) targets the lowest set bit of task_mask
// and returns one word with fired clear and last set, as does a scan word
// with run_enabled clear. A scan word with run_enabled set walks the slot
// store one slot a cycle, save while a held report waits on the output,
// through a single subtract-and-compare unit; every expired active slot is
// cleared and reported in ascending order, the final report carrying last. A
// scan that fires nothing returns one word with fired clear. The input is not
// ready during a scan, nor while a result word waits and is not taken.
module one_shot_task_timer_bank_unit #(
    parameter int SLOTS         = 16,
    parameter int TIMELINE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ottb_cmd_if.sink    i_cmd,
    ottb_res_if.source  o_res
);

    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PICK_N = (SLOTS < ottb_pkg::MASK_W) ? SLOTS : ottb_pkg::MASK_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_FLUSH
    } t_state;

    t_state                       r_state, n_state;
    logic [IDX_W-1:0]             r_idx, n_idx;
    logic [TIMELINE_BITS-1:0]     r_now, n_now;
    logic                         r_pend, n_pend;
    logic [IDX_W-1:0]             r_pend_slot, n_pend_slot;
    logic                         r_out_valid, n_out_valid;
    logic                         r_out_fired, n_out_fired;
    logic [ottb_pkg::SLOT_W-1:0]  r_out_slot, n_out_slot;
    logic                         r_out_last, n_out_last;

    logic                                out_free;
    logic                                accept;
    ottb_pkg::t_kind                     kind;
    logic                                sel_found;
    logic [IDX_W-1:0]                    sel_idx;
    logic [TIMELINE_BITS+ottb_pkg::NOW_W-1:0] now_ext;
    logic [TIMELINE_BITS-1:0]            now_tl;
    logic [IDX_W+ottb_pkg::SLOT_W-1:0]   pend_ext;

    ottb_pkg::t_store_ctl                ctl;
    logic [IDX_W-1:0]                    st_idx;
    logic [ottb_pkg::DELAY_W-1:0]        wdelay;
    logic [TIMELINE_BITS-1:0]            wstart;
    logic [ottb_pkg::DELAY_W-1:0]        rdelay;
    logic [TIMELINE_BITS-1:0]            rstart;
    logic [SLOTS-1:0]                    active;
    logic                                expired;
    logic                                hit;
    logic                                step;

    assign out_free     = !r_out_valid || o_res.ready;
    assign i_cmd.ready  = (r_state == S_IDLE) && out_free;
    assign accept       = i_cmd.valid && i_cmd.ready;
    assign kind         = ottb_pkg::t_kind'(i_cmd.kind);
    assign now_ext      = {{TIMELINE_BITS{1'b0}}, i_cmd.now};
    assign now_tl       = now_ext[TIMELINE_BITS-1:0];
    assign pend_ext     = {{ottb_pkg::SLOT_W{1'b0}}, r_pend_slot};

    assign o_res.valid  = r_out_valid;
    assign o_res.fired  = r_out_fired;
    assign o_res.slot   = r_out_slot;
    assign o_res.last   = r_out_last;

    // lowest set mask bit
    always_comb begin
        sel_found = 1'b0;
        sel_idx   = '0;
        for (int i = PICK_N - 1; i >= 0; i--) begin
            if (i_cmd.task_mask[i]) begin
                sel_found = 1'b1;
                sel_idx   = IDX_W'(i);
            end
        end
    end

    ottb_store #(
        .SLOTS         (SLOTS),
        .TIMELINE_BITS (TIMELINE_BITS),
        .IDX_W         (IDX_W)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_idx    (st_idx),
        .i_wdelay (wdelay),
        .i_wstart (wstart),
        .i_raddr  (n_idx),
        .o_rdelay (rdelay),
        .o_rstart (rstart),
        .o_active (active)
    );

    ottb_expiry #(
        .TIMELINE_BITS (TIMELINE_BITS)
    ) u_expiry (
        .i_now     (r_now),
        .i_start   (rstart),
        .i_delay   (rdelay),
        .o_expired (expired)
    );

    assign hit    = active[r_idx] && expired;
    assign st_idx = (r_state == S_CHECK) ? r_idx : sel_idx;
    assign wdelay = (kind == ottb_pkg::KIND_ARM) ? i_cmd.delay_ms : '0;
    assign wstart = (kind == ottb_pkg::KIND_STOP) ? '0 : now_tl;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_now       = r_now;
        n_pend      = r_pend;
        n_pend_slot = r_pend_slot;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_fired = r_out_fired;
        n_out_slot  = r_out_slot;
        n_out_last  = r_out_last;
        ctl         = '0;
        step        = 1'b0;

        case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (accept) begin
                    if (kind == ottb_pkg::KIND_SCAN && i_cmd.run_enabled) begin
                        n_state = S_CHECK;
                        n_now   = now_tl;
                        n_pend  = 1'b0;
                    end else begin
                        n_out_valid = 1'b1;
                        n_out_fired = 1'b0;
                        n_out_slot  = '0;
                        n_out_last  = 1'b1;
                        if (kind != ottb_pkg::KIND_SCAN && sel_found) begin
                            ctl.we      = 1'b1;
                            ctl.act_set = (kind != ottb_pkg::KIND_STOP);
                            ctl.act_clr = (kind == ottb_pkg::KIND_STOP);
                        end
                    end
                end
            end
            S_CHECK: begin
                // a held report goes out before the next one is taken
                step = !(hit && r_pend && !out_free);
                if (hit && step) begin
                    ctl.act_clr = 1'b1;
                    n_pend      = 1'b1;
                    n_pend_slot = r_idx;
                    if (r_pend) begin
                        n_out_valid = 1'b1;
                        n_out_fired = 1'b1;
                        n_out_slot  = pend_ext[ottb_pkg::SLOT_W-1:0];
                        n_out_last  = 1'b0;
                    end
                end
                if (step) begin
                    if (r_idx == LAST_IDX) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_fired = r_pend;
                    n_out_slot  = r_pend ? pend_ext[ottb_pkg::SLOT_W-1:0] : '0;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                    n_idx       = '0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_now       <= n_now;
        r_pend_slot <= n_pend_slot;
        r_out_fired <= n_out_fired;
        r_out_slot  <= n_out_slot;
        r_out_last  <= n_out_last;
    end

endmodule

FILE: design/ottb_expiry.sv
module ottb_expiry #(
    parameter int TIMELINE_BITS = 32
) (
    input  logic [TIMELINE_BITS-1:0]         i_now,
    input  logic [TIMELINE_BITS-1:0]         i_start,
    input  logic [ottb_pkg::DELAY_W-1:0]     i_delay,
    output logic                             o_expired
);

    logic [TIMELINE_BITS-1:0]                 elapsed;
    logic [TIMELINE_BITS+ottb_pkg::DELAY_W-1:0] delay_ext;

    // elapsed wraps modulo the timeline width
    assign elapsed   = i_now - i_start;
    assign delay_ext = {{TIMELINE_BITS{1'b0}}, i_delay};
    assign o_expired = elapsed >= delay_ext[TIMELINE_BITS-1:0];

endmodule

FILE: design/ottb_store.sv
module ottb_store #(
    parameter int SLOTS         = 16,
    parameter int TIMELINE_BITS = 32,
    parameter int IDX_W         = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ottb_pkg::t_store_ctl             i_ctl,
    input  logic [IDX_W-1:0]                 i_idx,
    input  logic [ottb_pkg::DELAY_W-1:0]     i_wdelay,
    input  logic [TIMELINE_BITS-1:0]         i_wstart,
    input  logic [IDX_W-1:0]                 i_raddr,
    output logic [ottb_pkg::DELAY_W-1:0]     o_rdelay,
    output logic [TIMELINE_BITS-1:0]         o_rstart,
    output logic [SLOTS-1:0]                 o_active
);

    localparam int ENT_W = ottb_pkg::DELAY_W + TIMELINE_BITS;

    logic [ENT_W-1:0] r_mem [SLOTS];
    logic [ENT_W-1:0] r_rdata;
    logic [SLOTS-1:0] r_active;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_idx] <= {i_wdelay, i_wstart};
        end
        r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if (i_ctl.act_set) begin
            r_active[i_idx] <= 1'b1;
        end else if (i_ctl.act_clr) begin
            r_active[i_idx] <= 1'b0;
        end
    end

    assign o_rdelay = r_rdata[ENT_W-1:TIMELINE_BITS];
    assign o_rstart = r_rdata[TIMELINE_BITS-1:0];
    assign o_active = r_active;

endmodule
